/* hw/rtl/stack_bytecode_executor_macros.svh */
// Assertion macros shared by the stack executor modules.
`ifndef STACK_BYTECODE_EXECUTOR_MACROS_SVH
`define STACK_BYTECODE_EXECUTOR_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SBE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define SBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sbe_pkg.sv */
// Shared types, codes and constants of the stack bytecode executor.
package sbe_pkg;

  localparam int unsigned StackDepthDef = 256;
  localparam int unsigned PoolDepthDef  = 256;
  localparam int unsigned ValueW        = 32;

  typedef enum logic [2:0] {
    CmdPoolWr = 3'd0,
    CmdConst  = 3'd1,
    CmdAdd    = 3'd2,
    CmdSub    = 3'd3,
    CmdMul    = 3'd4,
    CmdDiv    = 3'd5,
    CmdNeg    = 3'd6,
    CmdRet    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    KindEcho = 3'd0,
    KindRet  = 3'd1,
    KindOvf  = 3'd2,
    KindUnf  = 3'd3,
    KindDiv0 = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  pool_index;
    logic signed [31:0] pool_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic signed [31:0] result_value;
    logic        program_end;
  } out_item_t;

  // Classified instruction handed from the front end to the back end.
  typedef struct packed {
    cmd_e        cmd;
    logic        pool_hit;
    logic [31:0] pool_data;
  } op_t;

  localparam logic signed [31:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  // Clamp a 34-bit signed sum to Q16.16.
  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh0_7fff_ffff) r = QMax;
    else if (v < -34'sh0_8000_0000) r = QMin;
    else r = v[31:0];
    return r;
  endfunction

  // Apply a sign to a magnitude and clamp.
  function automatic logic [31:0] signed_sat(input logic [47:0] m, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (m > 48'h8000_0000) r = QMin;
      else r = 32'(-m);
    end else begin
      if (m > 48'h7fff_ffff) r = QMax;
      else r = m[31:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/sbe_if.sv */
// Valid/ready channel carrying one payload item.
interface sbe_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/sbe_front.sv */
// Front end: accepts items, serves pool writes and looks up the pool.
module sbe_front #(
  parameter int unsigned PoolDepth = sbe_pkg::PoolDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  sbe_if.sink  in_i,
  output logic op_valid_o,
  input  logic op_ready_i,
  output sbe_pkg::op_t op_o
);
  localparam int unsigned PoolAw = (PoolDepth > 1) ? $clog2(PoolDepth) : 1;

  logic [31:0] pool_q [PoolDepth];
  logic        valid_q;
  sbe_pkg::cmd_e cmd_q;
  logic        hit_q;
  logic [31:0] rd_q;
  logic        in_range;
  logic        take;

  assign in_range = 32'(in_i.data.pool_index) < PoolDepth;
  // A pool write finishes here; every item, pool writes too, needs a free output slot.
  assign in_i.ready = !valid_q || op_ready_i;
  assign take = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i) begin
    if (take && in_i.data.cmd == sbe_pkg::CmdPoolWr && in_range) begin
      pool_q[in_i.data.pool_index[PoolAw-1:0]] <= in_i.data.pool_value;
    end
    if (take) begin
      rd_q <= pool_q[in_i.data.pool_index[PoolAw-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cmd_q   <= sbe_pkg::CmdPoolWr;
      hit_q   <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid && in_i.data.cmd != sbe_pkg::CmdPoolWr;
      cmd_q   <= sbe_pkg::cmd_e'(in_i.data.cmd);
      hit_q   <= in_range;
    end
  end

  assign op_valid_o     = valid_q;
  assign op_o.cmd       = cmd_q;
  assign op_o.pool_hit  = hit_q;
  assign op_o.pool_data = rd_q;
endmodule

/* hw/rtl/sbe_queue.sv */
// Two-entry queue between the front and back ends.
module sbe_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  sbe_pkg::op_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output sbe_pkg::op_t rd_data_o
);
  sbe_pkg::op_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

/* hw/rtl/sbe_back.sv */
// Back end: stack memory, arithmetic sequencer and result register.
`include "stack_bytecode_executor_macros.svh"
module sbe_back #(
  parameter int unsigned StackDepth = sbe_pkg::StackDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic op_valid_i,
  output logic op_ready_o,
  input  sbe_pkg::op_t op_i,
  sbe_if.source out_o
);
  localparam int unsigned SpW = $clog2(StackDepth + 1);
  localparam int unsigned AW  = $clog2(StackDepth);

  typedef enum logic [2:0] {
    StIdle, StRead, StExec, StMul, StDiv, StFin, StOut
  } state_e;

  state_e state_q;
  logic [31:0] stk_q [StackDepth];
  logic [SpW-1:0] sp_q;
  sbe_pkg::cmd_e cmd_q;
  logic [31:0] a_q, b_q, top_q;
  logic [31:0] cdata_q;
  logic        neg_q;
  logic [47:0] ma_q;   // dividend bits still to be shifted into the remainder
  logic [63:0] prod_q;
  logic [48:0] quo_q;
  logic [32:0] den_q;
  logic [32:0] rem_q;
  logic [5:0]  cnt_q;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_data;
  sbe_pkg::out_item_t res_q;
  logic [31:0] mag_a, mag_b;
  logic [32:0] rem_sh;
  logic [33:0] rem_try;

  assign op_ready_o = state_q == StIdle;
  assign out_o.valid = state_q == StOut;
  assign out_o.data = res_q;

  assign mag_a = a_q[31] ? 32'(-a_q) : a_q;
  assign mag_b = b_q[31] ? 32'(-b_q) : b_q;
  assign rem_sh = {rem_q[31:0], ma_q[47]};
  assign rem_try = {1'b0, rem_sh} - {1'b0, den_q};

  // Stack memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) stk_q[wr_addr] <= wr_data;
    if (state_q == StIdle) top_q <= stk_q[AW'(sp_q - SpW'(1))];
    else if (state_q == StRead) top_q <= stk_q[AW'(sp_q - SpW'(2))];
  end

  // In the execute cycle top_q still holds the second entry from the top.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = AW'(sp_q);
    wr_data = cdata_q;
    unique case (state_q)
      StExec: begin
        if (cmd_q == sbe_pkg::CmdConst && 32'(sp_q) < StackDepth) begin
          wr_en = 1'b1;
        end else if (sp_q >= SpW'(2) &&
                     (cmd_q == sbe_pkg::CmdAdd || cmd_q == sbe_pkg::CmdSub)) begin
          wr_en = 1'b1;
          wr_addr = AW'(sp_q - SpW'(2));
          wr_data = (cmd_q == sbe_pkg::CmdAdd) ?
            sbe_pkg::sat34(34'(signed'(top_q)) + 34'(signed'(b_q))) :
            sbe_pkg::sat34(34'(signed'(top_q)) - 34'(signed'(b_q)));
        end else if (sp_q != '0 && cmd_q == sbe_pkg::CmdNeg) begin
          wr_en = 1'b1;
          wr_addr = AW'(sp_q - SpW'(1));
          wr_data = sbe_pkg::sat34(-34'(signed'(b_q)));
        end
      end
      StFin: begin
        wr_en = 1'b1;
        wr_addr = AW'(sp_q - SpW'(1));
        wr_data = (cmd_q == sbe_pkg::CmdMul) ?
          sbe_pkg::signed_sat(prod_q[63:16] + 48'(prod_q[15]), neg_q) :
          sbe_pkg::signed_sat(quo_q[48:1] + 48'(quo_q[0]), neg_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sp_q <= '0;
      cmd_q <= sbe_pkg::CmdPoolWr;
      res_q <= '0;
      cnt_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: if (op_valid_i) begin
          cmd_q <= op_i.cmd;
          cdata_q <= op_i.pool_hit ? op_i.pool_data : 32'd0;
          state_q <= StRead;
        end
        StRead: begin
          b_q <= top_q;
          state_q <= StExec;
        end
        StExec: begin
          a_q <= top_q;
          unique case (cmd_q)
            sbe_pkg::CmdConst: begin
              state_q <= StOut;
              if (32'(sp_q) < StackDepth) begin
                sp_q <= sp_q + SpW'(1);
                res_q <= '{kind: sbe_pkg::KindEcho, result_value: cdata_q, program_end: 1'b0};
              end else begin
                res_q <= '{kind: sbe_pkg::KindOvf, result_value: '0, program_end: 1'b0};
              end
            end
            sbe_pkg::CmdAdd, sbe_pkg::CmdSub, sbe_pkg::CmdMul, sbe_pkg::CmdDiv: begin
              if (sp_q < SpW'(2)) begin
                res_q <= '{kind: sbe_pkg::KindUnf, result_value: '0, program_end: 1'b0};
                state_q <= StOut;
              end else if (cmd_q == sbe_pkg::CmdAdd || cmd_q == sbe_pkg::CmdSub) begin
                sp_q <= sp_q - SpW'(1);
                state_q <= StIdle;
              end else if (cmd_q == sbe_pkg::CmdMul) begin
                state_q <= StMul;
              end else if (b_q == '0) begin
                res_q <= '{kind: sbe_pkg::KindDiv0, result_value: '0, program_end: 1'b0};
                state_q <= StOut;
              end else begin
                state_q <= StDiv;
              end
            end
            sbe_pkg::CmdNeg: begin
              if (sp_q == '0) begin
                res_q <= '{kind: sbe_pkg::KindUnf, result_value: '0, program_end: 1'b0};
                state_q <= StOut;
              end else begin
                state_q <= StIdle;
              end
            end
            sbe_pkg::CmdRet: begin
              state_q <= StOut;
              if (sp_q != '0) begin
                sp_q <= sp_q - SpW'(1);
                res_q <= '{kind: sbe_pkg::KindRet, result_value: b_q, program_end: 1'b1};
              end else begin
                res_q <= '{kind: sbe_pkg::KindUnf, result_value: '0, program_end: 1'b0};
              end
            end
            default: state_q <= StIdle;
          endcase
        end
        StMul: begin
          prod_q <= 64'(mag_a) * 64'(mag_b);
          neg_q <= a_q[31] ^ b_q[31];
          sp_q <= sp_q - SpW'(1);
          state_q <= StFin;
        end
        StDiv: begin
          // Restoring division of |a|<<17 by |b|, one quotient bit per cycle.
          if (cnt_q == 6'd0) begin
            neg_q <= a_q[31] ^ b_q[31];
            den_q <= {1'b0, mag_b};
            ma_q <= {mag_a, 16'd0};
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= 6'd1;
          end else begin
            if (rem_try[33]) rem_q <= rem_sh;
            else rem_q <= rem_try[32:0];
            quo_q <= {quo_q[47:0], !rem_try[33]};
            ma_q <= {ma_q[46:0], 1'b0};
            if (cnt_q == 6'd49) begin
              sp_q <= sp_q - SpW'(1);
              cnt_q <= 6'd0;
              state_q <= StFin;
            end else begin
              cnt_q <= cnt_q + 6'd1;
            end
          end
        end
        StFin: state_q <= StIdle;
        StOut: if (out_o.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  `SBE_ASSERT(a_sp_range, clk_i, rst_ni, 32'(sp_q) <= StackDepth, "stack pointer beyond depth")
  `SBE_ASSERT(a_ready_idle, clk_i, rst_ni, !(op_ready_o && out_o.valid), "ready while result pending")
  `SBE_ASSERT_NEXT(a_ret_end, clk_i, rst_ni, out_o.valid && res_q.kind == sbe_pkg::KindRet, res_q.program_end || !out_o.valid, "return without end mark")
endmodule

/* hw/rtl/stack_bytecode_executor.sv */
// Top level of the stack bytecode executor.
//  Channel | Dir | Payload
//  in_i    | in  | cmd, pool_index, pool_value
//  out_o   | out | kind, result_value, program_end
// Pool writes finish in the front end; other items pass back-end read and execute states;
// multiply adds product and finish states, divide bit-serial divide and finish states.
// An item with a result then enters the output register state.
// Results wait in an output register until taken; the back end stalls meanwhile.
// Reset (rst_ni low, asynchronous) empties the stack; pool and stack contents stay.
`include "stack_bytecode_executor_macros.svh"
module stack_bytecode_executor #(
  parameter int unsigned StackDepth = sbe_pkg::StackDepthDef,
  parameter int unsigned PoolDepth  = sbe_pkg::PoolDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  sbe_if.sink   in_i,
  sbe_if.source out_o
);
  logic f_valid, f_ready, q_valid, q_ready;
  sbe_pkg::op_t f_op, q_op;

  sbe_front #(.PoolDepth(PoolDepth)) u_front (
    .clk_i, .rst_ni, .in_i,
    .op_valid_o(f_valid), .op_ready_i(f_ready), .op_o(f_op)
  );

  sbe_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_op),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_op)
  );

  sbe_back #(.StackDepth(StackDepth)) u_back (
    .clk_i, .rst_ni,
    .op_valid_i(q_valid), .op_ready_o(q_ready), .op_i(q_op), .out_o
  );

  `SBE_ASSERT(a_out_kind, clk_i, rst_ni, !out_o.valid || out_o.data.kind <= sbe_pkg::KindDiv0, "bad result kind")
  `SBE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid, "result dropped")
endmodule

/* tb/stack_bytecode_executor_tb.sv */
// Self-checking testbench for the stack bytecode executor.
`timescale 1ns / 100ps
module stack_bytecode_executor_tb;

  localparam int unsigned Depth = sbe_pkg::StackDepthDef;

  // Holds the executor's architectural state and the queue of results it owes.
  class exec_scoreboard;
    logic signed [31:0] stack_q[Depth];
    logic signed [31:0] pool_q[sbe_pkg::PoolDepthDef];
    bit                 pool_valid[sbe_pkg::PoolDepthDef];
    int unsigned        depth;
    sbe_pkg::out_item_t owed[$];
    int                 errors;
    int                 checked;

    function void clear();
      depth = 0;
      foreach (pool_valid[i]) pool_valid[i] = 1'b0;
    endfunction

    function logic [31:0] clamp64(input logic signed [63:0] v);
      if (v > 64'sh7fff_ffff) return sbe_pkg::QMax;
      if (v < -64'sh8000_0000) return sbe_pkg::QMin;
      return v[31:0];
    endfunction

    function logic [31:0] mag_clamp(input logic [63:0] m, input bit neg);
      if (neg) return (m > 64'h8000_0000) ? sbe_pkg::QMin : 32'(-m);
      return (m > 64'h7fff_ffff) ? sbe_pkg::QMax : m[31:0];
    endfunction

    function void owe(input sbe_pkg::kind_e k, input logic [31:0] v, input logic e);
      sbe_pkg::out_item_t r;
      r.kind = k;
      r.result_value = v;
      r.program_end = e;
      owed.push_back(r);
    endfunction

    // Applies one accepted instruction and queues the result it causes, if any.
    function void note_input(input sbe_pkg::in_item_t it);
      logic signed [63:0] a, b;
      logic [63:0] ma, mb, m;
      logic [31:0] r;
      case (sbe_pkg::cmd_e'(it.cmd))
        sbe_pkg::CmdPoolWr: begin
          pool_q[it.pool_index] = it.pool_value;
          pool_valid[it.pool_index] = 1'b1;
        end
        sbe_pkg::CmdConst: begin
          if (depth >= Depth) owe(sbe_pkg::KindOvf, '0, 1'b0);
          else begin
            r = pool_q[it.pool_index];
            stack_q[depth] = r;
            depth++;
            owe(sbe_pkg::KindEcho, r, 1'b0);
          end
        end
        sbe_pkg::CmdNeg: begin
          if (depth == 0) owe(sbe_pkg::KindUnf, '0, 1'b0);
          else stack_q[depth-1] = clamp64(-64'(stack_q[depth-1]));
        end
        sbe_pkg::CmdRet: begin
          if (depth == 0) owe(sbe_pkg::KindUnf, '0, 1'b0);
          else begin
            depth--;
            owe(sbe_pkg::KindRet, stack_q[depth], 1'b1);
          end
        end
        default: begin
          if (depth < 2) owe(sbe_pkg::KindUnf, '0, 1'b0);
          else begin
            b = stack_q[depth-1];
            a = stack_q[depth-2];
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            if (sbe_pkg::cmd_e'(it.cmd) == sbe_pkg::CmdDiv && b == 0) begin
              owe(sbe_pkg::KindDiv0, '0, 1'b0);
              return;
            end
            case (sbe_pkg::cmd_e'(it.cmd))
              sbe_pkg::CmdAdd: r = clamp64(a + b);
              sbe_pkg::CmdSub: r = clamp64(a - b);
              sbe_pkg::CmdMul: begin
                m = (ma * mb + 64'h8000) >> 16;
                r = mag_clamp(m, (a < 0) != (b < 0));
              end
              default: begin
                m = (2 * (ma << 16) + mb) / (2 * mb);
                r = mag_clamp(m, (a < 0) != (b < 0));
              end
            endcase
            depth--;
            stack_q[depth-1] = r;
          end
        end
      endcase
    endfunction

    function void check_result(input sbe_pkg::out_item_t got);
      sbe_pkg::out_item_t exp;
      checked++;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result kind=%0d value=%h end=%b",
                                   got.kind, got.result_value, got.program_end);
        return;
      end
      exp = owed.pop_front();
      if (exp !== got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected kind=%0d value=%h end=%b, got kind=%0d value=%h end=%b",
                   exp.kind, exp.result_value, exp.program_end,
                   got.kind, got.result_value, got.program_end);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  sbe_if #(.T(sbe_pkg::in_item_t))  in_ch();
  sbe_if #(.T(sbe_pkg::out_item_t)) out_ch();

  stack_bytecode_executor DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  exec_scoreboard sb;
  bit   quiet_phase;
  bit   long_hold;
  int   sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // Output side: random stalls, one long hold-off, and checking.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (long_hold) out_ch.ready <= 1'b0;
      else if (gap > 0) begin
        gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(0, 15);
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
    end
  end

  // Sends one instruction, with an optional random gap before it.
  task automatic send_item(input sbe_pkg::cmd_e c, input logic [7:0] idx,
                           input logic [31:0] v);
    sbe_pkg::in_item_t it;
    int n;
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    it.cmd = c;
    it.pool_index = idx;
    it.pool_value = v;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(it);
    sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Only written pool entries are read, so constant picks among them.
  function automatic logic [7:0] written_idx();
    logic [7:0] i;
    do i = $urandom_range(0, 255); while (!sb.pool_valid[i]);
    return i;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return sbe_pkg::QMax;
      1: return sbe_pkg::QMin;
      2: return 32'($urandom_range(0, 4)) << 16;
      3: return -(32'($urandom_range(1, 3)) << 16);
      4: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int k;
    sbe_pkg::cmd_e c;
    sb = new();
    sb.clear();
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, underflow on empty stack, divide by zero, saturation.
    send_item(sbe_pkg::CmdPoolWr, 8'd0, sbe_pkg::QMax);
    send_item(sbe_pkg::CmdPoolWr, 8'd255, sbe_pkg::QMin);
    send_item(sbe_pkg::CmdPoolWr, 8'd1, 32'h0);
    send_item(sbe_pkg::CmdPoolWr, 8'd2, 32'h0000_8000);
    send_item(sbe_pkg::CmdPoolWr, 8'd3, 32'hffff_8000);
    send_item(sbe_pkg::CmdPoolWr, 8'd4, 32'h0001_0000);
    send_item(sbe_pkg::CmdRet, 8'd0, 32'h0);
    send_item(sbe_pkg::CmdNeg, 8'd0, 32'h0);
    send_item(sbe_pkg::CmdAdd, 8'd0, 32'h0);
    send_item(sbe_pkg::CmdConst, 8'd0, 32'h0);
    send_item(sbe_pkg::CmdConst, 8'd0, 32'h0);
    send_item(sbe_pkg::CmdAdd, 8'd0, 32'h0);
    send_item(sbe_pkg::CmdConst, 8'd255, 32'h0);
    send_item(sbe_pkg::CmdNeg, 8'd0, 32'h0);
    send_item(sbe_pkg::CmdConst, 8'd1, 32'h0);
    send_item(sbe_pkg::CmdDiv, 8'd0, 32'h0);
    send_item(sbe_pkg::CmdSub, 8'd0, 32'h0);
    send_item(sbe_pkg::CmdConst, 8'd2, 32'h0);
    send_item(sbe_pkg::CmdConst, 8'd3, 32'h0);
    send_item(sbe_pkg::CmdMul, 8'd0, 32'h0);
    send_item(sbe_pkg::CmdConst, 8'd4, 32'h0);
    send_item(sbe_pkg::CmdDiv, 8'd0, 32'h0);
    send_item(sbe_pkg::CmdRet, 8'd0, 32'h0);
    send_item(sbe_pkg::CmdRet, 8'd0, 32'h0);
    wait_drained();

    // Fill the stack past its depth while the receiver holds off.
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      for (k = 0; k < Depth + 3; k++) send_item(sbe_pkg::CmdConst, written_idx(), 32'h0);
    join
    wait_drained();
    while (sb.depth > 0) send_item(sbe_pkg::CmdRet, 8'd0, 32'h0);
    wait_drained();

    // Random programs: mostly short expression evaluations, some noise.
    while (sent < 1350) begin
      if (sent > 1150) quiet_phase = 1'b1;
      k = $urandom_range(0, 19);
      if (k < 3) send_item(sbe_pkg::CmdPoolWr, 8'($urandom), rand_value());
      else if (k < 8 && sb.depth < Depth - 2)
        send_item(sbe_pkg::CmdConst, written_idx(), $urandom);
      else if (k < 16) send_item(sbe_pkg::cmd_e'($urandom_range(2, 6)), 8'($urandom), $urandom);
      else if (k < 19) send_item(sbe_pkg::CmdRet, 8'($urandom), $urandom);
      else begin
        c = sbe_pkg::cmd_e'($urandom_range(0, 7));
        if (c == sbe_pkg::CmdConst) send_item(c, written_idx(), $urandom);
        else send_item(c, 8'($urandom) | 8'h80, $urandom);
      end
    end
    wait_drained();

    $display("Ran %0d instructions, %0d results checked, incl. overflow and hold-off.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.owed.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

/* stack_bytecode_executor.f */
+incdir+hw/rtl
hw/rtl/sbe_pkg.sv
hw/rtl/sbe_if.sv
hw/rtl/sbe_front.sv
hw/rtl/sbe_queue.sv
hw/rtl/sbe_back.sv
hw/rtl/stack_bytecode_executor.sv
tb/stack_bytecode_executor_tb.sv
